/* design/fac_pkg.sv */
// ----------------------------------------------------------------------------
// fac_pkg
// Shared commands, constants and pipeline control types for the frustum cull
// unit.
// ----------------------------------------------------------------------------
package fac_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_PLANE  = 2'd0,
    CMD_LOAD_CORNER = 2'd1,
    CMD_TEST_BOX    = 2'd2,
    CMD_TEST_POINT  = 2'd3
  } cmd_t;

  localparam int NUM_CORNERS = 8;
  localparam int NUM_AXES    = 3;

  // stage enables and test kind for one plane lane
  typedef struct packed {
    logic en_sel;
    logic en_mul;
    logic pnt;
  } lane_ctrl_t;

endpackage

/* design/fac_plane_lane.sv */
// ----------------------------------------------------------------------------
// fac_plane_lane
// One plane: picks the box vertex farthest along the normal or the test point,
// forms the three products and the exact plane value, and reports its sign.
// ----------------------------------------------------------------------------
module fac_plane_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  fac_pkg::lane_ctrl_t           ctrl,
  input  logic signed [COORD_WIDTH-1:0] coef [4],
  input  logic signed [COORD_WIDTH:0]   mn   [fac_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH:0]   mx   [fac_pkg::NUM_AXES],
  output logic                          neg
);

  localparam int PW  = 2 * COORD_WIDTH + 1;
  localparam int DW  = COORD_WIDTH + FRAC_BITS;
  localparam int SW  = ((PW > DW) ? PW : DW) + 3;

  logic signed [COORD_WIDTH-1:0] coef_r [4];
  logic signed [COORD_WIDTH:0]   vtx_r  [fac_pkg::NUM_AXES];
  logic signed [COORD_WIDTH:0]   vtx_nxt [fac_pkg::NUM_AXES];
  logic signed [PW-1:0]          prod_r [fac_pkg::NUM_AXES];
  logic signed [PW-1:0]          prod_nxt [fac_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] d_r;
  logic signed [SW-1:0]          sum;

  // positive vertex per axis, or the point itself
  always_comb begin
    for (int i = 0; i < fac_pkg::NUM_AXES; i++) begin
      if (ctrl.pnt) begin
        vtx_nxt[i] = mn[i];
      end else if (coef[i][COORD_WIDTH-1]) begin
        vtx_nxt[i] = (mx[i] < mn[i]) ? mx[i] : mn[i];
      end else begin
        vtx_nxt[i] = (mx[i] > mn[i]) ? mx[i] : mn[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_sel) begin
      coef_r <= coef;
      vtx_r  <= vtx_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < fac_pkg::NUM_AXES; i++) begin
      prod_nxt[i] = PW'(coef_r[i]) * PW'(vtx_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      prod_r <= prod_nxt;
      d_r    <= coef_r[3];
    end
  end

  assign sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2])
             + (SW'(d_r) <<< FRAC_BITS);
  assign neg = sum[SW-1];

endmodule

/* design/frustum_aabb_cull_unit.sv */
// ----------------------------------------------------------------------------
// frustum_aabb_cull_unit
// Frustum cull engine: plane and corner loads, box and point visibility tests.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless stalled and returns one result word per test
// after box bounds, vertex select and corner compare, multiply and plane sum
// into the output register. Every plane has its own lane of three multipliers,
// so the sustained rate is one box or point per cycle without output stalls.
// Loads write the stores in program order as they leave the second stage and
// give no result; a test issued right after a load sees the new values.
module frustum_aabb_cull_unit #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_slot,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_coef_c,
  input  logic signed [31:0] in_coef_d,
  input  logic signed [31:0] in_box_x,
  input  logic signed [31:0] in_box_y,
  input  logic signed [31:0] in_box_z,
  input  logic signed [31:0] in_extent_x,
  input  logic signed [31:0] in_extent_y,
  input  logic signed [31:0] in_extent_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_visible
);

  localparam int CW = COORD_WIDTH;
  localparam int NA = fac_pkg::NUM_AXES;
  localparam int NC = fac_pkg::NUM_CORNERS;

  logic rdy1, rdy2, rdy3, rdy4, rdy_out;

  // stage 1: input register
  logic                 v1_r;
  logic [1:0]           cmd1_r;
  logic [2:0]           slot1_r;
  logic signed [CW-1:0] coef1_r [4];
  logic signed [CW-1:0] mn1_r   [NA];
  logic signed [CW-1:0] ext1_r  [NA];

  // stage 2: box bounds, store access
  logic                 v2_r;
  logic [1:0]           cmd2_r;
  logic [2:0]           slot2_r;
  logic signed [CW-1:0] coef2_r [4];
  logic signed [CW:0]   mn2_r   [NA];
  logic signed [CW:0]   mx2_r   [NA];
  logic signed [CW:0]   mx2_nxt [NA];

  // stores
  logic signed [CW-1:0] plane_r  [NUM_PLANES][4];
  logic signed [CW-1:0] corner_r [NC][NA];

  // stages 3, 4 and output
  logic v3_r, pnt3_r, cull3_r, cull3_nxt;
  logic v4_r, pnt4_r, cull4_r;
  logic out_valid_r, visible_r;
  logic [NUM_PLANES-1:0] neg;
  logic is_test2, wr_plane, wr_corner;
  fac_pkg::lane_ctrl_t lane_ctrl;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy4     = !v4_r || rdy_out;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign is_test2  = (cmd2_r == fac_pkg::CMD_TEST_BOX) || (cmd2_r == fac_pkg::CMD_TEST_POINT);
  assign wr_plane  = v2_r && rdy3 && (cmd2_r == fac_pkg::CMD_LOAD_PLANE);
  assign wr_corner = v2_r && rdy3 && (cmd2_r == fac_pkg::CMD_LOAD_CORNER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r && is_test2;
      if (rdy4) v4_r <= v3_r;
      if (rdy_out) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      cmd1_r     <= in_command;
      slot1_r    <= in_slot;
      coef1_r[0] <= CW'(in_coef_a);
      coef1_r[1] <= CW'(in_coef_b);
      coef1_r[2] <= CW'(in_coef_c);
      coef1_r[3] <= CW'(in_coef_d);
      mn1_r[0]   <= CW'(in_box_x);
      mn1_r[1]   <= CW'(in_box_y);
      mn1_r[2]   <= CW'(in_box_z);
      ext1_r[0]  <= CW'(in_extent_x);
      ext1_r[1]  <= CW'(in_extent_y);
      ext1_r[2]  <= CW'(in_extent_z);
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      mx2_nxt[i] = (CW+1)'(mn1_r[i]) + (CW+1)'(ext1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      cmd2_r  <= cmd1_r;
      slot2_r <= slot1_r;
      coef2_r <= coef1_r;
      for (int i = 0; i < NA; i++) begin
        mn2_r[i] <= (CW+1)'(mn1_r[i]);
      end
      mx2_r <= mx2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (wr_plane && (slot2_r == 3'(p))) begin
        plane_r[p] <= coef2_r;
      end
    end
    for (int k = 0; k < NC; k++) begin
      if (wr_corner && (slot2_r == 3'(k))) begin
        for (int i = 0; i < NA; i++) begin
          corner_r[k][i] <= coef2_r[i];
        end
      end
    end
  end

  // frustum corners all beyond one face of the box
  always_comb begin
    logic above, below;
    cull3_nxt = 1'b0;
    for (int i = 0; i < NA; i++) begin
      above = 1'b1;
      below = 1'b1;
      for (int k = 0; k < NC; k++) begin
        if (!((CW+1)'(corner_r[k][i]) > mx2_r[i])) above = 1'b0;
        if (!((CW+1)'(corner_r[k][i]) < mn2_r[i])) below = 1'b0;
      end
      if (above || below) cull3_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      pnt3_r  <= (cmd2_r == fac_pkg::CMD_TEST_POINT);
      cull3_r <= cull3_nxt;
    end
    if (rdy4 && v3_r) begin
      pnt4_r  <= pnt3_r;
      cull4_r <= cull3_r;
    end
    if (rdy_out && v4_r) begin
      visible_r <= !(|neg) && (pnt4_r || !cull4_r);
    end
  end

  assign lane_ctrl.en_sel = rdy3 && v2_r;
  assign lane_ctrl.en_mul = rdy4 && v3_r;
  assign lane_ctrl.pnt    = (cmd2_r == fac_pkg::CMD_TEST_POINT);

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fac_plane_lane #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .ctrl(lane_ctrl),
      .coef(plane_r[p]),
      .mn  (mn2_r),
      .mx  (mx2_r),
      .neg (neg[p])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;

  // loads never reach the multiply stage
  a_load_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && rdy3 && !is_test2) |=> !v3_r)
    else $error("load word entered stage 3");

  // a result only follows a word in stage 4
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!v4_r && rdy_out) |=> !out_valid_r)
    else $error("result without a word in stage 4");

  // input stall only when every stage and the output register are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r))
    else $error("input stalled with a free stage");

endmodule
